/* hw/rtl/deque_with_cursor_macros.svh */
`ifndef DEQUE_WITH_CURSOR_MACROS_SVH
`define DEQUE_WITH_CURSOR_MACROS_SVH

// cons must hold in the cycle where ante holds
`define DWC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwc check failed");

// cons must hold in the cycle after ante holds
`define DWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwc check failed");

`endif

/* hw/rtl/dwc_pkg.sv */
package dwc_pkg;

  localparam int WORD_W = 32;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [TYPE_W-1:0] REQ_PUSH_LEFT  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_RIGHT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_LEFT   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_RIGHT  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CUR_LEFT   = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_CUR_RIGHT  = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SET        = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_PEEK       = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_END   = 2'd3;

  localparam logic [1:0] RD_POP    = 2'd0;
  localparam logic [1:0] RD_LEFT   = 2'd1;
  localparam logic [1:0] RD_RIGHT  = 2'd2;
  localparam logic [1:0] RD_CURSOR = 2'd3;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       exec;
    logic       cap_left;
    logic       cap_right;
    logic       load_out;
  } dwc_cmd_t;

  typedef struct packed {
    logic out_free;
  } dwc_stat_t;

endpackage

/* hw/rtl/dwc_req_if.sv */
interface dwc_req_if;
  import dwc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

/* hw/rtl/dwc_rsp_if.sv */
interface dwc_rsp_if #(
  parameter int CW = 5
);
  import dwc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] popped;
  logic signed [WORD_W-1:0] left_value;
  logic signed [WORD_W-1:0] right_value;
  logic signed [WORD_W-1:0] cursor_value;
  logic [CW-1:0]            count;
  logic                     is_empty;

  modport source (output valid, status, popped, left_value, right_value, cursor_value,
                  count, is_empty, input ready);
  modport sink (input valid, status, popped, left_value, right_value, cursor_value,
                count, is_empty, output ready);
endinterface

/* hw/rtl/dwc_ctrl.sv */
module dwc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  dwc_pkg::dwc_stat_t stat,
  output dwc_pkg::dwc_cmd_t  cmd
);
  import dwc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_RDL  = 3'd3;
  localparam logic [2:0] S_RDR  = 3'd4;
  localparam logic [2:0] S_RDC  = 3'd5;
  localparam logic [2:0] S_CAP  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = req_valid;
        if (req_valid) state_next = S_POP;
      end
      S_POP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_POP;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RDL;
      end
      S_RDL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LEFT;
        state_next = S_RDR;
      end
      S_RDR: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_RIGHT;
        cmd.cap_left = 1'b1;
        state_next   = S_RDC;
      end
      S_RDC: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_CURSOR;
        cmd.cap_right = 1'b1;
        state_next    = S_CAP;
      end
      S_CAP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/dwc_dp.sv */
`include "deque_with_cursor_macros.svh"

module dwc_dp #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dwc_pkg::dwc_cmd_t                 cmd,
  output dwc_pkg::dwc_stat_t                stat,
  input  logic [dwc_pkg::TYPE_W-1:0]        req_type,
  input  logic signed [dwc_pkg::WORD_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [dwc_pkg::STAT_W-1:0]        status,
  output logic signed [dwc_pkg::WORD_W-1:0] popped,
  output logic signed [dwc_pkg::WORD_W-1:0] left_value,
  output logic signed [dwc_pkg::WORD_W-1:0] right_value,
  output logic signed [dwc_pkg::WORD_W-1:0] cursor_value,
  output logic [CW-1:0]                     count,
  output logic                              is_empty
);
  import dwc_pkg::*;

  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [IW:0]   DEPTH_W   = (IW+1)'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[IW-1:0];
  endfunction

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [IW-1:0]     head;
  logic [CW-1:0]     fill;
  logic [IW-1:0]     cursor;
  logic [TYPE_W-1:0] req_code;
  logic [WORD_W-1:0] wr_value;
  logic [STAT_W-1:0] item_status;
  logic [WORD_W-1:0] item_popped;
  logic [WORD_W-1:0] left_word;
  logic [WORD_W-1:0] right_word;

  logic [IW-1:0]     head_next;
  logic [CW-1:0]     fill_next;
  logic [IW-1:0]     cursor_next;
  logic [STAT_W-1:0] st_new;
  logic [WORD_W-1:0] pop_word;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;

  logic              empty;
  logic              full;
  logic [CW-1:0]     fill_m1;
  logic [CW-1:0]     fill_m2;
  logic [IW-1:0]     last_off;
  logic [IW-1:0]     head_dec;
  logic [IW-1:0]     head_inc;
  logic [CW-1:0]     cursor_w;

  assign empty    = (fill == '0);
  assign full     = (fill == FULL_CNT);
  assign fill_m1  = fill - CW'(1);
  assign fill_m2  = fill - CW'(2);
  assign last_off = fill_m1[IW-1:0];
  assign head_dec = (head == '0) ? LAST_SLOT : head - IW'(1);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + IW'(1);
  assign cursor_w = CW'(cursor);

  assign stat.out_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_POP:    rd_addr = (req_code == REQ_POP_LEFT) ? head : wrap_add(head, last_off);
      RD_LEFT:   rd_addr = head;
      RD_RIGHT:  rd_addr = wrap_add(head, last_off);
      RD_CURSOR: rd_addr = wrap_add(head, cursor);
      default:   rd_addr = head;
    endcase
  end

  always_comb begin
    head_next   = head;
    fill_next   = fill;
    cursor_next = cursor;
    st_new      = ST_OK;
    pop_word    = '0;
    wr_en       = 1'b0;
    wr_addr     = head_dec;
    case (req_code)
      REQ_PUSH_LEFT: begin
        if (full) begin
          st_new = ST_FULL;
        end else begin
          head_next   = head_dec;
          wr_en       = 1'b1;
          wr_addr     = head_dec;
          cursor_next = empty ? '0 : cursor + IW'(1);
          fill_next   = fill + CW'(1);
        end
      end
      REQ_PUSH_RIGHT: begin
        if (full) begin
          st_new = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = wrap_add(head, fill[IW-1:0]);
          fill_next = fill + CW'(1);
          if (empty) cursor_next = '0;
        end
      end
      REQ_POP_LEFT: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else begin
          pop_word  = rd_data;
          head_next = head_inc;
          fill_next = fill_m1;
          if (cursor != '0) cursor_next = cursor - IW'(1);
          if (fill_m1 == '0) begin
            cursor_next = '0;
            head_next   = '0;
          end
        end
      end
      REQ_POP_RIGHT: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else begin
          pop_word  = rd_data;
          fill_next = fill_m1;
          if (fill_m1 == '0) begin
            cursor_next = '0;
            head_next   = '0;
          end else if (cursor_w >= fill_m1) begin
            cursor_next = fill_m2[IW-1:0];
          end
        end
      end
      REQ_CUR_LEFT: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else if (cursor == '0) begin
          st_new = ST_END;
        end else begin
          cursor_next = cursor - IW'(1);
        end
      end
      REQ_CUR_RIGHT: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else if (cursor_w + CW'(1) >= fill) begin
          st_new = ST_END;
        end else begin
          cursor_next = cursor + IW'(1);
        end
      end
      REQ_SET: begin
        if (empty) begin
          st_new = ST_EMPTY;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wrap_add(head, cursor);
        end
      end
      REQ_PEEK: begin
        if (empty) st_new = ST_EMPTY;
      end
      default: begin
        if (empty) st_new = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= wr_value;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      fill   <= '0;
      cursor <= '0;
    end else if (cmd.exec) begin
      head   <= head_next;
      fill   <= fill_next;
      cursor <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_code <= req_type;
      wr_value <= value;
    end
    if (cmd.exec) begin
      item_status <= st_new;
      item_popped <= pop_word;
    end
    if (cmd.cap_left) left_word <= rd_data;
    if (cmd.cap_right) right_word <= rd_data;
    if (cmd.load_out) begin
      status       <= item_status;
      popped       <= item_popped;
      left_value   <= empty ? '0 : left_word;
      right_value  <= empty ? '0 : right_word;
      cursor_value <= empty ? '0 : rd_data;
      count        <= fill;
      is_empty     <= empty;
    end
  end

  `DWC_ASSERT_SAME(a_cursor_in_range, fill != '0, cursor_w < fill)
  `DWC_ASSERT_SAME(a_empty_home, fill == '0, head == '0 && cursor == '0)
  `DWC_ASSERT_SAME(a_load_when_free, cmd.load_out, !rsp_valid || rsp_ready)
  `DWC_ASSERT_NEXT(a_pop_shrinks, cmd.exec && (req_code == REQ_POP_LEFT || req_code == REQ_POP_RIGHT) && fill != '0, fill == $past(fill) - CW'(1))

endmodule

/* hw/rtl/deque_with_cursor.sv */
// Bounded double-ended queue of signed 32-bit words held in a DEPTH-slot ring, with a
// cursor on one element. Each request word (push or pop at either end, cursor move,
// overwrite at the cursor, peek) yields one response word with the status, popped word,
// both end words, cursor word, count and empty flag after the request. A request is handled
// in full before the next one is taken: the slot memory has a single registered read port,
// so the popped word and then the left, right and cursor words are read one after another,
// with the pointer and slot update in between. The next request is taken as soon as the
// previous response sits in the output register; a response that is still held there
// stalls only the final step of the following request. Slots need no clearing after
// reset, so requests are taken in the first cycle after reset is released.
module deque_with_cursor #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  dwc_req_if.sink   req,
  dwc_rsp_if.source rsp
);
  import dwc_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dwc_cmd_t  cmd;
  dwc_stat_t stat;

  dwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dwc_dp #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .value        (req.value),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .popped       (rsp.popped),
    .left_value   (rsp.left_value),
    .right_value  (rsp.right_value),
    .cursor_value (rsp.cursor_value),
    .count        (rsp.count),
    .is_empty     (rsp.is_empty)
  );

endmodule

/* tb/sv/deque_with_cursor_tb.sv */
module deque_with_cursor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwc_pkg::*;

  localparam int DEPTH = 16;
  localparam int CW = 5;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES = 22;
  localparam int PHASE_LEN = 50;

  localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] W_NEG1 = 32'hffff_ffff;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN,
    MIX_CURSOR
  } op_mix_e;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped;
    logic signed [WORD_W-1:0] left_value;
    logic signed [WORD_W-1:0] right_value;
    logic signed [WORD_W-1:0] cursor_value;
    logic [CW-1:0]            count;
    logic                     is_empty;
  } deque_view_t;

  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [WORD_W-1:0] word;
    int                times;
    bit                known;
    deque_view_t       view;
  } plan_row_t;

  logic clk;
  logic rst;

  dwc_req_if req_ch ();
  dwc_rsp_if #(.CW(CW)) rsp_ch ();

  deque_with_cursor #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [WORD_W-1:0] ring [DEPTH];
  logic [3:0]        head_idx;
  logic [CW-1:0]     fill;
  logic [3:0]        cur_off;

  deque_view_t view_q [$];
  bit          calm;
  bit          row_known;
  deque_view_t row_view;
  int          errors;
  int          quiet;
  int          n_taken;
  int          n_checked;
  int          n_full;
  int          n_empty;
  int          n_end;

  plan_row_t plan [];

  always #5 clk = ~clk;

  function automatic deque_view_t mk_view(logic [STAT_W-1:0] st, logic [WORD_W-1:0] pv,
                                          logic [WORD_W-1:0] lv, logic [WORD_W-1:0] rv,
                                          logic [WORD_W-1:0] cv, int n);
    deque_view_t v;
    v.status = st;
    v.popped = pv;
    v.left_value = lv;
    v.right_value = rv;
    v.cursor_value = cv;
    v.count = CW'(n);
    v.is_empty = (n == 0);
    return v;
  endfunction

  function automatic logic [3:0] slot_of(logic [CW-1:0] off);
    return head_idx + off[3:0];
  endfunction

  function automatic deque_view_t apply_request(logic [TYPE_W-1:0] kind,
                                                logic [WORD_W-1:0] word);
    deque_view_t v;
    v = '0;
    v.status = ST_OK;
    case (kind)
      REQ_PUSH_LEFT: begin
        if (fill == CW'(DEPTH)) begin
          v.status = ST_FULL;
        end else begin
          head_idx = head_idx - 4'd1;
          ring[head_idx] = word;
          cur_off = (fill == 0) ? 4'd0 : cur_off + 4'd1;
          fill = fill + CW'(1);
        end
      end
      REQ_PUSH_RIGHT: begin
        if (fill == CW'(DEPTH)) begin
          v.status = ST_FULL;
        end else begin
          ring[slot_of(fill)] = word;
          if (fill == 0) cur_off = 4'd0;
          fill = fill + CW'(1);
        end
      end
      REQ_POP_LEFT: begin
        if (fill == 0) begin
          v.status = ST_EMPTY;
        end else begin
          v.popped = ring[head_idx];
          head_idx = head_idx + 4'd1;
          fill = fill - CW'(1);
          if (cur_off != 0) cur_off = cur_off - 4'd1;
          if (fill == 0) begin
            cur_off = 4'd0;
            head_idx = 4'd0;
          end
        end
      end
      REQ_POP_RIGHT: begin
        if (fill == 0) begin
          v.status = ST_EMPTY;
        end else begin
          v.popped = ring[slot_of(fill - CW'(1))];
          fill = fill - CW'(1);
          if (fill == 0) begin
            cur_off = 4'd0;
            head_idx = 4'd0;
          end else if (CW'(cur_off) >= fill) begin
            cur_off = 4'(fill - CW'(1));
          end
        end
      end
      REQ_CUR_LEFT: begin
        if (fill == 0) v.status = ST_EMPTY;
        else if (cur_off == 0) v.status = ST_END;
        else cur_off = cur_off - 4'd1;
      end
      REQ_CUR_RIGHT: begin
        if (fill == 0) v.status = ST_EMPTY;
        else if (int'(cur_off) + 1 >= int'(fill)) v.status = ST_END;
        else cur_off = cur_off + 4'd1;
      end
      REQ_SET: begin
        if (fill == 0) v.status = ST_EMPTY;
        else ring[slot_of(CW'(cur_off))] = word;
      end
      default: begin
        if (fill == 0) v.status = ST_EMPTY;
      end
    endcase
    if (fill != 0) begin
      v.left_value = ring[slot_of('0)];
      v.right_value = ring[slot_of(fill - CW'(1))];
      v.cursor_value = ring[slot_of(CW'(cur_off))];
    end
    v.count = fill;
    v.is_empty = (fill == 0);
    return v;
  endfunction

  task automatic compare_view(deque_view_t exp_v, deque_view_t got);
    if (got.status !== exp_v.status) begin
      $error("status: expected %0d, got %0d", exp_v.status, got.status);
      errors++;
    end
    if (got.popped !== exp_v.popped) begin
      $error("popped: expected %0d, got %0d", exp_v.popped, got.popped);
      errors++;
    end
    if (got.left_value !== exp_v.left_value) begin
      $error("left_value: expected %0d, got %0d", exp_v.left_value, got.left_value);
      errors++;
    end
    if (got.right_value !== exp_v.right_value) begin
      $error("right_value: expected %0d, got %0d", exp_v.right_value, got.right_value);
      errors++;
    end
    if (got.cursor_value !== exp_v.cursor_value) begin
      $error("cursor_value: expected %0d, got %0d", exp_v.cursor_value, got.cursor_value);
      errors++;
    end
    if (got.count !== exp_v.count) begin
      $error("count: expected %0d, got %0d", exp_v.count, got.count);
      errors++;
    end
    if (got.is_empty !== exp_v.is_empty) begin
      $error("is_empty: expected %0d, got %0d", exp_v.is_empty, got.is_empty);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deque_view_t predicted;
    deque_view_t got;
    bit          moved;
    moved = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_request(req_ch.req_type, req_ch.value);
        if (row_known) predicted = row_view;
        view_q.push_back(predicted);
        n_taken++;
        if (predicted.status == ST_FULL) n_full++;
        if (predicted.status == ST_EMPTY) n_empty++;
        if (predicted.status == ST_END) n_end++;
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.popped = rsp_ch.popped;
        got.left_value = rsp_ch.left_value;
        got.right_value = rsp_ch.right_value;
        got.cursor_value = rsp_ch.cursor_value;
        got.count = rsp_ch.count;
        got.is_empty = rsp_ch.is_empty;
        if (view_q.size() == 0) begin
          $error("unexpected response word: status %0d count %0d", got.status, got.count);
          errors++;
        end else begin
          compare_view(view_q.pop_front(), got);
          n_checked++;
        end
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(logic [TYPE_W-1:0] kind, logic [WORD_W-1:0] word, bit known,
                           deque_view_t view);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value <= word;
    row_known <= known;
    row_view <= view;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic [TYPE_W-1:0] pick_op(op_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 60) return (r < 30) ? REQ_PUSH_LEFT : REQ_PUSH_RIGHT;
        if (r < 70) return (r < 65) ? REQ_POP_LEFT : REQ_POP_RIGHT;
      end
      MIX_SHRINK: begin
        if (r < 60) return (r < 30) ? REQ_POP_LEFT : REQ_POP_RIGHT;
        if (r < 70) return (r < 65) ? REQ_PUSH_LEFT : REQ_PUSH_RIGHT;
      end
      MIX_CURSOR: begin
        if (r < 70) return TYPE_W'($urandom_range(REQ_CUR_LEFT, REQ_PEEK));
      end
      default: ;
    endcase
    return TYPE_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return W_MIN;
      1: return W_MAX;
      2: return '0;
      3: return W_NEG1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PEEK;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    head_idx = '0;
    fill = '0;
    cur_off = '0;
    calm = 1'b0;
    row_known = 1'b0;
    row_view = '0;
    errors = 0;
    quiet = 0;
    n_taken = 0;
    n_checked = 0;
    n_full = 0;
    n_empty = 0;
    n_end = 0;
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    deque_view_t e0;
    deque_view_t none;
    op_mix_e     mix;
    e0 = mk_view(ST_EMPTY, '0, '0, '0, '0, 0);
    none = '0;
    plan = '{
      '{REQ_POP_LEFT, '0, 1, 1'b1, e0},
      '{REQ_POP_RIGHT, '0, 1, 1'b1, e0},
      '{REQ_CUR_LEFT, '0, 1, 1'b1, e0},
      '{REQ_CUR_RIGHT, '0, 1, 1'b1, e0},
      '{REQ_SET, W_NEG1, 1, 1'b1, e0},
      '{REQ_PEEK, '0, 1, 1'b1, e0},
      '{REQ_PUSH_RIGHT, W_MAX, 1, 1'b1, mk_view(ST_OK, '0, W_MAX, W_MAX, W_MAX, 1)},
      '{REQ_CUR_LEFT, '0, 1, 1'b1, mk_view(ST_END, '0, W_MAX, W_MAX, W_MAX, 1)},
      '{REQ_CUR_RIGHT, '0, 1, 1'b1, mk_view(ST_END, '0, W_MAX, W_MAX, W_MAX, 1)},
      '{REQ_PUSH_LEFT, W_MIN, 1, 1'b1, mk_view(ST_OK, '0, W_MIN, W_MAX, W_MAX, 2)},
      '{REQ_SET, '0, 1, 1'b1, mk_view(ST_OK, '0, W_MIN, '0, '0, 2)},
      '{REQ_CUR_LEFT, '0, 1, 1'b1, mk_view(ST_OK, '0, W_MIN, '0, W_MIN, 2)},
      '{REQ_POP_LEFT, '0, 1, 1'b1, mk_view(ST_OK, W_MIN, '0, '0, '0, 1)},
      '{REQ_POP_RIGHT, '0, 1, 1'b1, mk_view(ST_OK, '0, '0, '0, '0, 0)},
      '{REQ_PUSH_LEFT, W_NEG1, 1, 1'b1, mk_view(ST_OK, '0, W_NEG1, W_NEG1, W_NEG1, 1)},
      '{REQ_PUSH_RIGHT, 32'h5555_5555, DEPTH - 1, 1'b0, none},
      '{REQ_PUSH_RIGHT, 32'haaaa_aaaa, 1, 1'b0, none},
      '{REQ_PUSH_LEFT, 32'h0000_0001, 1, 1'b0, none},
      '{REQ_CUR_RIGHT, '0, DEPTH, 1'b0, none},
      '{REQ_POP_RIGHT, '0, 1, 1'b0, none},
      '{REQ_SET, 32'h1234_5678, 1, 1'b0, none},
      '{REQ_PEEK, '0, 1, 1'b0, none},
      '{REQ_POP_LEFT, '0, DEPTH, 1'b0, none}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].times) send_word(plan[i].kind, plan[i].word, plan[i].known, plan[i].view);
    end

    for (int p = 0; p < PHASES; p++) begin
      mix = op_mix_e'($urandom_range(0, 3));
      calm = ($urandom_range(0, 3) == 0);
      if (p == PHASES / 2) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (view_q.size() != 0) @(posedge clk);
      end
      repeat (PHASE_LEN) send_word(pick_op(mix), pick_word(), 1'b0, none);
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d request words, checked %0d response words", n_taken, n_checked);
    $display("full pushes %0d, requests on empty %0d, cursor moves past an end %0d",
             n_full, n_empty, n_end);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
